// ----- hdl/alw_pkg.sv -----
package alw_pkg;

	// event kinds carried by cmd
	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_ARM    = 2'd1,
		CMD_SUBMIT = 2'd2,
		CMD_STOP   = 2'd3
	} cmd_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK           = 2'd0,
		ST_REFUSED      = 2'd1,
		ST_TRIP_CMD     = 2'd2,
		ST_TRIP_TIMEOUT = 2'd3
	} status_t;

	// configuration register indexes
	typedef enum logic [2:0] {
		REG_STEER_MIN = 3'd0,
		REG_STEER_MAX = 3'd1,
		REG_MOTOR_NEU = 3'd2,
		REG_MOTOR_MIN = 3'd3,
		REG_MOTOR_MAX = 3'd4,
		REG_LEASE     = 3'd5,
		REG_MAX_RUN   = 3'd6
	} reg_idx_t;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;
	localparam int DRIVE_W    = 16;
	localparam int LEASE_W    = 9;
	localparam int RUN_W      = 14;

	// register reset values
	localparam int STEER_MIN_RST = 1000;
	localparam int STEER_MAX_RST = 2000;
	localparam int MOTOR_NEU_RST = 1500;
	localparam int MOTOR_MIN_RST = 1550;
	localparam int MOTOR_MAX_RST = 2000;
	localparam logic [LEASE_W-1:0] LEASE_RST   = 9'd100;
	localparam logic [RUN_W-1:0]   MAX_RUN_RST = 14'd5000;

endpackage

// ----- hdl/actuator_lease_watchdog.sv -----
// channel  | direction | handshake              | payload
// ---------+-----------+------------------------+-----------------------------------------
// in       | sink      | in_valid / in_stall    | cmd, steering, motor
// out      | source    | out_valid / out_stall  | status, drive_write, drive_steering,
//          |           |                        | drive_motor, force_neutral, init_pulse,
//          |           |                        | is_tripped, is_armed
// cfg      | sink      | cfg_valid / cfg_ready  | cfg_index, cfg_data
//
// one item per cycle sustained while the output is not stalled; an item is captured in the
// input register, and its result then appears from the result register
// the event decode, envelope compares and lease/run checks sit between those registers
// reset clears the flags, ages and both stage valids; registers take their default values
// a stalled result holds in the result register while one more item waits in the input
// register; the input stalls only when both are full and the output is stalled
module actuator_lease_watchdog #(
	parameter int PULSE_WIDTH = 16
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// item input
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       cmd,
	input  logic [PULSE_WIDTH-1:0]           steering,
	input  logic [PULSE_WIDTH-1:0]           motor,
	// result output
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [1:0]                       status,
	output logic                             drive_write,
	output logic [alw_pkg::DRIVE_W-1:0]      drive_steering,
	output logic [alw_pkg::DRIVE_W-1:0]      drive_motor,
	output logic                             force_neutral,
	output logic                             init_pulse,
	output logic                             is_tripped,
	output logic                             is_armed,
	// configuration writes
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [alw_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [alw_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam logic [alw_pkg::LEASE_W-1:0] LeaseSat = '1;
	localparam logic [alw_pkg::RUN_W-1:0]   RunSat   = '1;

	// configuration registers
	logic [PULSE_WIDTH-1:0]        steer_min_q, steer_max_q;
	logic [PULSE_WIDTH-1:0]        motor_neu_q, motor_min_q, motor_max_q;
	logic [alw_pkg::LEASE_W-1:0]   lease_q;
	logic [alw_pkg::RUN_W-1:0]     max_run_q;

	// guard state
	logic                          armed_q, stopping_q, trip_q, driving_q;
	logic [alw_pkg::LEASE_W-1:0]   refresh_age_q;
	logic [alw_pkg::RUN_W-1:0]     run_age_q;

	// input stage
	logic                          valid_s1;
	alw_pkg::cmd_t                 cmd_s1;
	logic [PULSE_WIDTH-1:0]        steer_s1, motor_s1;

	// result stage
	logic                          valid_s2;
	alw_pkg::status_t              status_s2;
	logic                          dw_s2, fneu_s2, init_s2, trip_s2, armed_s2;
	logic [alw_pkg::DRIVE_W-1:0]   ds_s2, dm_s2;

	// next-state logic results
	logic                          armed_d, stopping_d, trip_d, driving_d;
	logic [alw_pkg::LEASE_W-1:0]   refresh_age_d;
	logic [alw_pkg::RUN_W-1:0]     run_age_d;
	alw_pkg::status_t              status_d;
	logic                          dw_d, fneu_d, init_d;
	logic [alw_pkg::DRIVE_W-1:0]   ds_d, dm_d;

	logic                          load_s2, load_s1;
	logic [alw_pkg::LEASE_W-1:0]   refresh_tick;
	logic [alw_pkg::RUN_W-1:0]     run_tick;
	logic                          expired_tick, expired_now, bad_cmd, can_drive;

	// flow control
	assign load_s2   = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall  = valid_s1 && !load_s2;
	assign load_s1   = in_valid && !in_stall;
	assign cfg_ready = 1'b1;

	// configuration write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			steer_min_q <= PULSE_WIDTH'(alw_pkg::STEER_MIN_RST);
			steer_max_q <= PULSE_WIDTH'(alw_pkg::STEER_MAX_RST);
			motor_neu_q <= PULSE_WIDTH'(alw_pkg::MOTOR_NEU_RST);
			motor_min_q <= PULSE_WIDTH'(alw_pkg::MOTOR_MIN_RST);
			motor_max_q <= PULSE_WIDTH'(alw_pkg::MOTOR_MAX_RST);
			lease_q     <= alw_pkg::LEASE_RST;
			max_run_q   <= alw_pkg::MAX_RUN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (alw_pkg::reg_idx_t'(cfg_index))
				alw_pkg::REG_STEER_MIN: steer_min_q <= cfg_data[PULSE_WIDTH-1:0];
				alw_pkg::REG_STEER_MAX: steer_max_q <= cfg_data[PULSE_WIDTH-1:0];
				alw_pkg::REG_MOTOR_NEU: motor_neu_q <= cfg_data[PULSE_WIDTH-1:0];
				alw_pkg::REG_MOTOR_MIN: motor_min_q <= cfg_data[PULSE_WIDTH-1:0];
				alw_pkg::REG_MOTOR_MAX: motor_max_q <= cfg_data[PULSE_WIDTH-1:0];
				alw_pkg::REG_LEASE:     lease_q     <= cfg_data[alw_pkg::LEASE_W-1:0];
				alw_pkg::REG_MAX_RUN:   max_run_q   <= cfg_data[alw_pkg::RUN_W-1:0];
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load_s1) begin
			valid_s1 <= 1'b1;
		end else if (load_s2) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s1) begin
			cmd_s1   <= alw_pkg::cmd_t'(cmd);
			steer_s1 <= steering;
			motor_s1 <= motor;
		end
	end

	// saturating ages as a tick would leave them
	assign refresh_tick = (driving_q && refresh_age_q != LeaseSat) ?
		refresh_age_q + 1'b1 : refresh_age_q;
	assign run_tick = (driving_q && run_age_q != RunSat) ? run_age_q + 1'b1 : run_age_q;

	// lease or run expired, on ticked and on current ages
	assign expired_tick = driving_q && (refresh_tick >= lease_q || run_tick >= max_run_q);
	assign expired_now  = driving_q && (refresh_age_q >= lease_q || run_age_q >= max_run_q);

	// envelope check; neutral motor is always accepted
	assign bad_cmd = steer_s1 < steer_min_q || steer_s1 > steer_max_q ||
		(motor_s1 != motor_neu_q && (motor_s1 < motor_min_q || motor_s1 > motor_max_q));

	assign can_drive = armed_q && !stopping_q && !trip_q;

	// event decode
	always_comb begin
		armed_d       = armed_q;
		stopping_d    = stopping_q;
		trip_d        = trip_q;
		driving_d     = driving_q;
		refresh_age_d = refresh_age_q;
		run_age_d     = run_age_q;
		status_d      = alw_pkg::ST_OK;
		dw_d          = 1'b0;
		fneu_d        = 1'b0;
		init_d        = 1'b0;
		ds_d          = '0;
		dm_d          = '0;
		case (cmd_s1)
			alw_pkg::CMD_TICK: begin
				refresh_age_d = refresh_tick;
				run_age_d     = run_tick;
				if (can_drive && expired_tick) begin
					trip_d   = 1'b1;
					fneu_d   = 1'b1;
					status_d = alw_pkg::ST_TRIP_TIMEOUT;
				end
			end
			alw_pkg::CMD_ARM: begin
				if (armed_q || stopping_q || trip_q) begin
					status_d = alw_pkg::ST_REFUSED;
				end else begin
					init_d  = 1'b1;
					fneu_d  = 1'b1;
					armed_d = 1'b1;
				end
			end
			alw_pkg::CMD_SUBMIT: begin
				if (!can_drive) begin
					status_d = alw_pkg::ST_REFUSED;
				end else if (expired_now || bad_cmd) begin
					trip_d   = 1'b1;
					fneu_d   = 1'b1;
					status_d = expired_now ? alw_pkg::ST_TRIP_TIMEOUT : alw_pkg::ST_TRIP_CMD;
				end else begin
					if (!driving_q && motor_s1 != motor_neu_q) begin
						driving_d = 1'b1;
						run_age_d = '0;
					end
					refresh_age_d = '0;
					dw_d          = 1'b1;
					ds_d          = alw_pkg::DRIVE_W'(steer_s1);
					dm_d          = alw_pkg::DRIVE_W'(motor_s1);
				end
			end
			alw_pkg::CMD_STOP: begin
				stopping_d = 1'b1;
				fneu_d     = armed_q;
				armed_d    = 1'b0;
			end
			default: ;
		endcase
	end

	// guard state advances as the item moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			armed_q       <= 1'b0;
			stopping_q    <= 1'b0;
			trip_q        <= 1'b0;
			driving_q     <= 1'b0;
			refresh_age_q <= '0;
			run_age_q     <= '0;
		end else if (load_s2) begin
			armed_q       <= armed_d;
			stopping_q    <= stopping_d;
			trip_q        <= trip_d;
			driving_q     <= driving_d;
			refresh_age_q <= refresh_age_d;
			run_age_q     <= run_age_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (load_s2) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_s2) begin
			status_s2 <= status_d;
			dw_s2     <= dw_d;
			ds_s2     <= ds_d;
			dm_s2     <= dm_d;
			fneu_s2   <= fneu_d;
			init_s2   <= init_d;
			trip_s2   <= trip_d;
			armed_s2  <= armed_d;
		end
	end

	assign out_valid      = valid_s2;
	assign status         = status_s2;
	assign drive_write    = dw_s2;
	assign drive_steering = ds_s2;
	assign drive_motor    = dm_s2;
	assign force_neutral  = fneu_s2;
	assign init_pulse     = init_s2;
	assign is_tripped     = trip_s2;
	assign is_armed       = armed_s2;

	// trip latch holds until reset
	a_trip_holds: assert property (@(posedge clk) disable iff (!arst_n)
		trip_q |=> trip_q)
		else $error("trip latch cleared");

	// armed and stopping are never both set
	a_arm_stop: assert property (@(posedge clk) disable iff (!arst_n)
		!(armed_q && stopping_q))
		else $error("armed while stopping");

	// a passed command never comes with neutral forcing or a bad status
	a_drive_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && dw_s2) |-> (status_s2 == alw_pkg::ST_OK && !fneu_s2))
		else $error("drive write with trip");

	// input only stalls behind a stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_stall && valid_s2))
		else $error("input stalled without output stall");

endmodule
